/* rtl/core/plcap_pkg.sv */
// ----------------------------------------------------------------------------
// plcap_pkg
// Types, codes and character constants for the direct-address text parser.
// ----------------------------------------------------------------------------
package plcap_pkg;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_CAT   = 3'd1,
    PH_TYPE  = 3'd2,
    PH_INDEX = 3'd3,
    PH_DOT   = 3'd4,
    PH_BIT   = 3'd5
  } phase_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_FMT  = 3'd1;
  localparam logic [2:0] ST_IDX_OVF  = 3'd2;
  localparam logic [2:0] ST_BIT_RNG  = 3'd3;
  localparam logic [2:0] ST_BIT_TYPE = 3'd4;

  localparam logic [1:0] CAT_I = 2'd0;
  localparam logic [1:0] CAT_Q = 2'd1;
  localparam logic [1:0] CAT_M = 2'd2;
  localparam logic [1:0] CAT_S = 2'd3;

  localparam logic [2:0] TY_X = 3'd0;
  localparam logic [2:0] TY_B = 3'd1;
  localparam logic [2:0] TY_W = 3'd2;
  localparam logic [2:0] TY_D = 3'd3;
  localparam logic [2:0] TY_L = 3'd4;
  localparam logic [2:0] TY_R = 3'd5;
  localparam logic [2:0] TY_F = 3'd6;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  localparam logic [6:0] BIT_MAX = 7'd63;
  localparam logic [6:0] BIT_SAT = 7'd64;

  typedef struct packed {
    logic       hit;
    logic [2:0] code;
  } code_hit_t;

  function automatic code_hit_t category_code(input logic [7:0] u);
    code_hit_t r;
    r.hit  = 1'b1;
    r.code = 3'd0;
    case (u)
      8'h49:   r.code = {1'b0, CAT_I};
      8'h51:   r.code = {1'b0, CAT_Q};
      8'h4D:   r.code = {1'b0, CAT_M};
      8'h53:   r.code = {1'b0, CAT_S};
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic code_hit_t type_code(input logic [7:0] u);
    code_hit_t r;
    r.hit  = 1'b1;
    r.code = TY_X;
    case (u)
      8'h58:   r.code = TY_X;
      8'h42:   r.code = TY_B;
      8'h57:   r.code = TY_W;
      8'h44:   r.code = TY_D;
      8'h4C:   r.code = TY_L;
      8'h52:   r.code = TY_R;
      8'h46:   r.code = TY_F;
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  // log2 of the element size in bytes
  function automatic logic [1:0] type_shift(input logic [2:0] t);
    logic [1:0] s;
    case (t)
      TY_W:       s = 2'd1;
      TY_D, TY_R: s = 2'd2;
      TY_L, TY_F: s = 2'd3;
      default:    s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/plc_address_text_parser.sv */
// ----------------------------------------------------------------------------
// plc_address_text_parser
// Character-serial parser for PLC direct-address text (%IX0.3, %MW12, ...).
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_ready   | ch, has_char, last
//  out     | out_valid / out_ready | status, category, data_type, byte_offset,
//          |                       | bit_position, has_bit
//
//  One beat per cycle on the input; parse state updates in the accepting cycle.
//  A beat with last set loads the result register; it shows on out the next cycle.
//  in_ready drops only while a result sits in the output register and out_ready
//  is low. Synchronous reset clears the parse state and out_valid.
// ----------------------------------------------------------------------------
module plc_address_text_parser #(
  parameter int INDEX_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        has_char,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [1:0]  category,
  output logic [2:0]  data_type,
  output logic [63:0] byte_offset,
  output logic [5:0]  bit_position,
  output logic        has_bit
);
  import plcap_pkg::*;

  localparam int IW = INDEX_BITS;

  phase_t          phase, phase_next;
  logic [1:0]      percent_seen, percent_seen_next;
  logic [1:0]      category_held, category_held_next;
  logic [2:0]      type_held, type_held_next;
  logic [IW-1:0]   index_value, index_value_next;
  logic            index_too_big, index_too_big_next;
  logic [6:0]      bit_value, bit_value_next;
  logic            bit_given, bit_given_next;
  logic            syntax_bad, syntax_bad_next;

  logic            accept;
  logic [7:0]      upper;
  logic            is_digit;
  logic [3:0]      digit;
  code_hit_t       cat_hit, ty_hit;
  logic [IW+3:0]   index_acc;
  logic [9:0]      bit_acc;
  logic            end_bad;
  logic [2:0]      res_status;
  logic [63:0]     offset_ext;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  assign upper    = (ch >= CH_LOW_A && ch <= CH_LOW_Z) ? ch - CASE_GAP : ch;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign digit    = is_digit ? 4'(ch - CH_ZERO) : 4'd0;
  assign cat_hit  = category_code(upper);
  assign ty_hit   = type_code(upper);

  // index*10 + d; anything above IW bits is overflow
  assign index_acc = ({4'd0, index_value} << 3) + ({4'd0, index_value} << 1)
                   + (IW+4)'(digit);
  assign bit_acc   = ({3'd0, bit_value} << 3) + ({3'd0, bit_value} << 1) + 10'(digit);

  always_comb begin
    phase_next         = phase;
    percent_seen_next  = percent_seen;
    category_held_next = category_held;
    type_held_next     = type_held;
    index_value_next   = index_value;
    index_too_big_next = index_too_big;
    bit_value_next     = bit_value;
    bit_given_next     = bit_given;
    syntax_bad_next    = syntax_bad;

    if (has_char && !syntax_bad) begin
      case (phase)
        PH_START: begin
          if (ch == CH_PERCENT) begin
            if (percent_seen >= 2'd2) syntax_bad_next = 1'b1;
            else percent_seen_next = percent_seen + 2'd1;
          end else if (cat_hit.hit) begin
            category_held_next = cat_hit.code[1:0];
            phase_next         = PH_CAT;
          end else begin
            syntax_bad_next = 1'b1;
          end
        end
        PH_CAT, PH_TYPE, PH_INDEX: begin
          if (phase == PH_CAT && ty_hit.hit) begin
            type_held_next = ty_hit.code;
            phase_next     = PH_TYPE;
          end else if (is_digit) begin
            phase_next = PH_INDEX;
            if (!index_too_big) begin
              if (|index_acc[IW+3:IW]) begin
                index_too_big_next = 1'b1;
                index_value_next   = '0;
              end else begin
                index_value_next = index_acc[IW-1:0];
              end
            end
          end else if (ch == CH_DOT && phase == PH_INDEX) begin
            bit_given_next = 1'b1;
            phase_next     = PH_DOT;
          end else begin
            syntax_bad_next = 1'b1;
          end
        end
        PH_DOT, PH_BIT: begin
          if (is_digit) begin
            bit_value_next = (bit_acc > 10'(BIT_MAX)) ? BIT_SAT : bit_acc[6:0];
            phase_next     = PH_BIT;
          end else begin
            syntax_bad_next = 1'b1;
          end
        end
        default: syntax_bad_next = 1'b1;
      endcase
    end
  end

  assign end_bad = syntax_bad_next || phase_next == PH_START || phase_next == PH_DOT;

  always_comb begin
    if (end_bad)                                      res_status = ST_BAD_FMT;
    else if (index_too_big_next)                      res_status = ST_IDX_OVF;
    else if (bit_given_next && bit_value_next > BIT_MAX) res_status = ST_BIT_RNG;
    else if (bit_given_next && type_held_next != TY_X)   res_status = ST_BIT_TYPE;
    else                                              res_status = ST_OK;
  end

  assign offset_ext = 64'(index_value_next) << type_shift(type_held_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      percent_seen  <= '0;
      category_held <= CAT_I;
      type_held     <= TY_X;
      index_value   <= '0;
      index_too_big <= 1'b0;
      bit_value     <= '0;
      bit_given     <= 1'b0;
      syntax_bad    <= 1'b0;
    end else if (accept) begin
      if (last) begin
        phase         <= PH_START;
        percent_seen  <= '0;
        category_held <= CAT_I;
        type_held     <= TY_X;
        index_value   <= '0;
        index_too_big <= 1'b0;
        bit_value     <= '0;
        bit_given     <= 1'b0;
        syntax_bad    <= 1'b0;
      end else begin
        phase         <= phase_next;
        percent_seen  <= percent_seen_next;
        category_held <= category_held_next;
        type_held     <= type_held_next;
        index_value   <= index_value_next;
        index_too_big <= index_too_big_next;
        bit_value     <= bit_value_next;
        bit_given     <= bit_given_next;
        syntax_bad    <= syntax_bad_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // error results carry all-zero fields
  always_ff @(posedge clk) begin
    if (accept && last) begin
      status <= res_status;
      if (res_status == ST_OK) begin
        category     <= category_held_next;
        data_type    <= type_held_next;
        byte_offset  <= offset_ext;
        bit_position <= bit_given_next ? bit_value_next[5:0] : 6'd0;
        has_bit      <= bit_given_next;
      end else begin
        category     <= CAT_I;
        data_type    <= TY_X;
        byte_offset  <= '0;
        bit_position <= '0;
        has_bit      <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/plcap_checker.sv */
// ----------------------------------------------------------------------------
// plcap_checker
// Port-level checks on the direct-address parser, bound into every parser instance.
// ----------------------------------------------------------------------------
module plcap_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [1:0]  category,
  input logic [2:0]  data_type,
  input logic [63:0] byte_offset,
  input logic [5:0]  bit_position,
  input logic        has_bit
);
  import plcap_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(byte_offset))
    else $error("result beat changed while stalled");

  // the closing beat of a string yields a result next cycle
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> out_valid)
    else $error("no result after end of string");

  // a mid-string beat never produces a result of its own
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last && (!out_valid || out_ready) |=> !out_valid)
    else $error("result without end of string");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> category == CAT_I && data_type == TY_X &&
      byte_offset == 64'd0 && bit_position == 6'd0 && !has_bit)
    else $error("error result with nonzero fields");

  a_bit_type: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK && has_bit |-> data_type == TY_X)
    else $error("bit suffix accepted on non-bit type");

endmodule

bind plc_address_text_parser plcap_checker u_plcap_checker (.*);
